// ===== rtl/svr_pkg.sv =====
// Shared types, constants and register codes of the sphere voxelizer.
`default_nettype none
package svr_pkg;

	// Grid and run limits
	localparam int MAX_DIM     = 1024;
	localparam int QUEUE_DEPTH = 4;
	localparam int IDX_W       = 10;
	localparam int LEN_W       = 11;

	// Configuration port geometry: 64-bit registers at 8-byte steps
	localparam int CFG_DATA_W  = 64;
	localparam int CFG_ADDR_W  = 6;
	localparam int CFG_IDX_LSB = 3;
	localparam int CFG_IDX_W   = 3;

	// Register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ORIGIN_X  = 3'd0,
		REG_ORIGIN_Y  = 3'd1,
		REG_ORIGIN_Z  = 3'd2,
		REG_SPACING_X = 3'd3,
		REG_SPACING_Y = 3'd4,
		REG_SPACING_Z = 3'd5,
		REG_RADIUS_SQ = 3'd6
	} cfg_reg_t;

	// Register contents, axis order x, y, z
	typedef struct packed {
		logic signed [2:0][31:0] origin;
		logic [2:0][30:0]        spacing;
		logic [62:0]             radius_sq;
	} cfg_t;

	// One voxel item
	typedef struct packed {
		logic [IDX_W-1:0] index_x;
		logic [IDX_W-1:0] index_y;
		logic [IDX_W-1:0] index_z;
		logic             last_voxel;
	} in_item_t;

	// One result item
	typedef struct packed {
		logic             inside_res;
		logic             run_done;
		logic [IDX_W-1:0] run_start_x;
		logic [IDX_W-1:0] run_start_y;
		logic [IDX_W-1:0] run_start_z;
		logic [LEN_W-1:0] run_length;
	} out_item_t;

	// Classified voxel between front and back
	typedef struct packed {
		logic     in_sphere;
		in_item_t vox;
	} q_item_t;

endpackage
`default_nettype wire

// ===== rtl/svr_stream_if.sv =====
// Valid/ready stream channel carrying one item type.
`default_nettype none
interface svr_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/svr_cfg.sv =====
// APB-style configuration registers of the sphere voxelizer.
`default_nettype none
module svr_cfg (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [svr_pkg::CFG_ADDR_W-1:0]   paddr,
	input  wire logic [svr_pkg::CFG_DATA_W-1:0]   pwdata,
	output logic      [svr_pkg::CFG_DATA_W-1:0]   prdata,
	output logic                                  pready,
	output svr_pkg::cfg_t                         cfg
);

	svr_pkg::cfg_t    cfg_q;
	svr_pkg::cfg_reg_t reg_idx;
	logic             wr_en;

	assign reg_idx = svr_pkg::cfg_reg_t'(
		paddr[svr_pkg::CFG_IDX_LSB +: svr_pkg::CFG_IDX_W]);
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	// Register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin    <= '0;
			cfg_q.spacing   <= {3{31'd65536}};
			cfg_q.radius_sq <= 63'h1_0000_0000;
		end else if (wr_en) begin
			case (reg_idx)
				svr_pkg::REG_ORIGIN_X:  cfg_q.origin[0]  <= pwdata[31:0];
				svr_pkg::REG_ORIGIN_Y:  cfg_q.origin[1]  <= pwdata[31:0];
				svr_pkg::REG_ORIGIN_Z:  cfg_q.origin[2]  <= pwdata[31:0];
				svr_pkg::REG_SPACING_X: cfg_q.spacing[0] <= pwdata[30:0];
				svr_pkg::REG_SPACING_Y: cfg_q.spacing[1] <= pwdata[30:0];
				svr_pkg::REG_SPACING_Z: cfg_q.spacing[2] <= pwdata[30:0];
				svr_pkg::REG_RADIUS_SQ: cfg_q.radius_sq  <= pwdata[62:0];
				default: ;
			endcase
		end
	end

	// Read mux
	always_comb begin
		case (reg_idx)
			svr_pkg::REG_ORIGIN_X:  prdata = {32'd0, cfg_q.origin[0]};
			svr_pkg::REG_ORIGIN_Y:  prdata = {32'd0, cfg_q.origin[1]};
			svr_pkg::REG_ORIGIN_Z:  prdata = {32'd0, cfg_q.origin[2]};
			svr_pkg::REG_SPACING_X: prdata = {33'd0, cfg_q.spacing[0]};
			svr_pkg::REG_SPACING_Y: prdata = {33'd0, cfg_q.spacing[1]};
			svr_pkg::REG_SPACING_Z: prdata = {33'd0, cfg_q.spacing[2]};
			svr_pkg::REG_RADIUS_SQ: prdata = {1'b0, cfg_q.radius_sq};
			default:                prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/svr_front.sv =====
// Front pipeline: per-axis offset, saturation, squaring and inside test.
`default_nettype none
module svr_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire svr_pkg::cfg_t     cfg,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire svr_pkg::in_item_t in_data,
	output logic                   q_valid,
	input  wire logic              q_ready,
	output svr_pkg::q_item_t       q_data
);

	// Clamp a 43-bit signed offset to 32 bits and return its magnitude
	function automatic logic [31:0] sat_mag(input logic signed [42:0] s);
		logic [31:0] c;
		if (!s[42] && (|s[41:31]))
			c = 32'h7FFF_FFFF;
		else if (s[42] && !(&s[41:31]))
			c = 32'h8000_0000;
		else
			c = s[31:0];
		return c[31] ? (~c + 32'd1) : c;
	endfunction

	logic adv;

	logic                   v_s1, v_s2, v_s3, v_s4, v_s5;
	svr_pkg::in_item_t      meta_s1, meta_s2, meta_s3, meta_s4, meta_s5;
	logic [2:0][40:0]       prod_s1;
	logic [2:0][31:0]       mag_s2;
	logic [2:0][62:0]       sq_s3;
	logic [63:0]            sxy_s4;
	logic [62:0]            sz_s4;
	logic                   in_sphere_s5;

	logic [2:0][svr_pkg::IDX_W-1:0] idx;
	logic [2:0][40:0]       prod_d;
	logic [2:0][31:0]       mag_d;
	logic [2:0][62:0]       sq_d;
	logic [63:0]            d2;

	// Whole pipeline moves unless the last stage is blocked by the queue
	assign adv      = !v_s5 || q_ready;
	assign in_ready = adv;
	assign q_valid  = v_s5;
	assign q_data   = '{in_sphere: in_sphere_s5, vox: meta_s5};

	assign idx = {in_data.index_z, in_data.index_y, in_data.index_x};

	// Per-axis datapath between stages; origin is sign-extended
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			prod_d[a] = 41'(idx[a]) * 41'(cfg.spacing[a]);
			mag_d[a]  = sat_mag(43'($signed(cfg.origin[a])) +
				$signed({2'b00, prod_s1[a]}));
			sq_d[a]   = 63'(64'(mag_s2[a]) * 64'(mag_s2[a]));
		end
		d2 = sxy_s4 + 64'(sz_s4);
	end

	// Stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// Stage payload
	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s1      <= in_data;
			prod_s1      <= prod_d;
			meta_s2      <= meta_s1;
			mag_s2       <= mag_d;
			meta_s3      <= meta_s2;
			sq_s3        <= sq_d;
			meta_s4      <= meta_s3;
			sxy_s4       <= 64'(sq_s3[0]) + 64'(sq_s3[1]);
			sz_s4        <= sq_s3[2];
			meta_s5      <= meta_s4;
			in_sphere_s5 <= d2 < 64'(cfg.radius_sq);
		end
	end

endmodule
`default_nettype wire

// ===== rtl/svr_queue.sv =====
// Short FIFO between the classifier and the run tracker.
`default_nettype none
module svr_queue #(
	parameter int DEPTH = svr_pkg::QUEUE_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push_valid,
	output logic                  push_ready,
	input  wire svr_pkg::q_item_t push_data,
	output logic                  pop_valid,
	input  wire logic             pop_ready,
	output svr_pkg::q_item_t      pop_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	svr_pkg::q_item_t entry_q [DEPTH];
	logic [PW-1:0]    wptr_q, rptr_q;
	logic [CW-1:0]    count_q;
	logic             push, pop;

	assign push_ready = count_q != CW'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = entry_q[rptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			if (pop)
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (push)
			entry_q[wptr_q] <= push_data;
	end

`ifndef ASSERT_OFF
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count did not follow a push");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop_ready && pop_valid |-> count_q != '0 && count_q <= CW'(DEPTH))
		else $error("queue popped outside its fill range");
`endif

endmodule
`default_nettype wire

// ===== rtl/svr_back.sv =====
// Back end: row run tracker and result register.
`default_nettype none
module svr_back #(
	parameter int MAX_DIM = svr_pkg::MAX_DIM
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             q_valid,
	output logic                  q_ready,
	input  wire svr_pkg::q_item_t q_data,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output svr_pkg::out_item_t    out_data
);

	localparam int LEN_CAP = (MAX_DIM < 2047) ? MAX_DIM : 2047;
	localparam int IW = svr_pkg::IDX_W;
	localparam int LW = svr_pkg::LEN_W;

	logic               run_open_q;
	logic [IW-1:0]      start_x_q, start_y_q, start_z_q;
	logic [LW-1:0]      len_q;
	logic               out_valid_q;
	svr_pkg::out_item_t out_q;

	logic               pop;
	logic               open_d;
	logic [IW-1:0]      sx_d, sy_d, sz_d;
	logic [LW-1:0]      len_d;
	svr_pkg::out_item_t res_d;

	assign q_ready   = !out_valid_q || out_ready;
	assign pop       = q_valid && q_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Run update: row start close, then inside/outside, then final flush
	always_comb begin
		logic reported;
		open_d   = run_open_q;
		sx_d     = start_x_q;
		sy_d     = start_y_q;
		sz_d     = start_z_q;
		len_d    = len_q;
		reported = 1'b0;
		res_d    = '0;
		res_d.inside_res = q_data.in_sphere;

		if (q_data.vox.index_x == '0 && open_d) begin
			res_d.run_done    = 1'b1;
			res_d.run_start_x = sx_d;
			res_d.run_start_y = sy_d;
			res_d.run_start_z = sz_d;
			res_d.run_length  = len_d;
			open_d   = 1'b0;
			reported = 1'b1;
		end

		if (q_data.in_sphere) begin
			if (!open_d) begin
				open_d = 1'b1;
				sx_d   = q_data.vox.index_x;
				sy_d   = q_data.vox.index_y;
				sz_d   = q_data.vox.index_z;
				len_d  = '0;
			end
			if (len_d < LW'(LEN_CAP))
				len_d = len_d + 1'b1;
		end else if (open_d) begin
			res_d.run_done    = 1'b1;
			res_d.run_start_x = sx_d;
			res_d.run_start_y = sy_d;
			res_d.run_start_z = sz_d;
			res_d.run_length  = len_d;
			open_d   = 1'b0;
			reported = 1'b1;
		end

		if (q_data.vox.last_voxel && open_d && !reported) begin
			res_d.run_done    = 1'b1;
			res_d.run_start_x = sx_d;
			res_d.run_start_y = sy_d;
			res_d.run_start_z = sz_d;
			res_d.run_length  = len_d;
			open_d = 1'b0;
		end
	end

	// Run state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_open_q  <= 1'b0;
			start_x_q   <= '0;
			start_y_q   <= '0;
			start_z_q   <= '0;
			len_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				run_open_q <= open_d;
				start_x_q  <= sx_d;
				start_y_q  <= sy_d;
				start_z_q  <= sz_d;
				len_q      <= len_d;
			end
			if (pop)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (pop)
			out_q <= res_d;
	end

`ifndef ASSERT_OFF
	a_run_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.run_done |-> out_q.run_length != '0)
		else $error("reported run has zero length");
	a_outside_closes: assert property (@(posedge clk) disable iff (!arst_n)
		pop && run_open_q && !q_data.in_sphere |=> out_q.run_done && !run_open_q)
		else $error("outside voxel did not close the open run");
`endif

endmodule
`default_nettype wire

// ===== rtl/sphere_voxelizer_run_length.sv =====
// Top level of the sphere voxelizer with row run-length output.
//
// Voxel items enter on the voxel channel in raster order (x fastest) and
// leave on the result channel, one result item per voxel, in the same order.
// Each result gives the inside flag and, when a run along a row closed on
// this voxel, the run's start indices and length.
// Registers are written over the APB-style port, 64-bit data, register i at
// byte address 8*i; write them only while no item is in flight.
// Path: a voxel passes the five-stage classifier, the queue and the result
// register before its result is valid.
// Throughput: one item per cycle while the receiver does not stall, set by the
// run tracker update in the back end and the fully pipelined classifier.
// Reset clears the run state and the in-flight items and loads the register
// defaults; there is no clearing pass.
// When the receiver stalls, the result register holds its item, the
// queue between classifier and tracker absorbs up to QUEUE_DEPTH items,
// and then the classifier freezes and voxel.ready drops.
`default_nettype none
module sphere_voxelizer_run_length #(
	parameter int MAX_DIM     = svr_pkg::MAX_DIM,
	parameter int QUEUE_DEPTH = svr_pkg::QUEUE_DEPTH
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	svr_stream_if.sink                          voxel,
	svr_stream_if.source                        result,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [svr_pkg::CFG_ADDR_W-1:0] paddr,
	input  wire logic [svr_pkg::CFG_DATA_W-1:0] pwdata,
	output logic      [svr_pkg::CFG_DATA_W-1:0] prdata,
	output logic                                pready
);

	svr_pkg::cfg_t     cfg;
	svr_pkg::in_item_t vox_data;
	svr_pkg::out_item_t res_data;
	logic              push_valid, push_ready;
	svr_pkg::q_item_t  push_data;
	logic              pop_valid, pop_ready;
	svr_pkg::q_item_t  pop_data;
	logic              res_valid;

	assign vox_data     = voxel.data;
	assign result.data  = res_data;
	assign result.valid = res_valid;

	// Configuration registers
	svr_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Classifier
	svr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_valid (voxel.valid),
		.in_ready (voxel.ready),
		.in_data  (vox_data),
		.q_valid  (push_valid),
		.q_ready  (push_ready),
		.q_data   (push_data)
	);

	// Decoupling queue
	svr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	// Run tracker
	svr_back #(
		.MAX_DIM (MAX_DIM)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (pop_valid),
		.q_ready   (pop_ready),
		.q_data    (pop_data),
		.out_valid (res_valid),
		.out_ready (result.ready),
		.out_data  (res_data)
	);

endmodule
`default_nettype wire

// ===== tb/sphere_voxelizer_run_length_tb.sv =====
// Self-checking testbench for the sphere voxelizer: inside test and row run encoding.
`default_nettype none
module sphere_voxelizer_run_length_tb;

	localparam int LEN_CAP = (svr_pkg::MAX_DIM < 2047) ? svr_pkg::MAX_DIM : 2047;
	localparam int QUIET_LIMIT = 1000;
	localparam int PHASE_ITEMS = 20;
	localparam int SAT_ITEMS = 1030;
	localparam logic [svr_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam int ORG_MIN = 32'sh8000_0000;
	localparam int ORG_MAX = 32'sh7FFF_FFFF;
	localparam longint OFS_MAX = 64'sd2147483647;
	localparam longint OFS_MIN = -64'sd2147483648;
	localparam logic [30:0] STEP_ONE = 31'd65536;
	localparam logic [30:0] STEP_MAX = 31'h7FFF_FFFF;

	// Mirror of the block: register copy, run state, results still owed
	class voxel_checker;
		int          origin[3];
		logic [30:0] spacing[3];
		logic [62:0] radius_sq;
		bit          run_open;
		logic [svr_pkg::IDX_W-1:0] open_x, open_y, open_z;
		logic [svr_pkg::LEN_W-1:0] open_len;
		svr_pkg::out_item_t due_results[$];
		int unsigned mismatches;

		function new();
			for (int a = 0; a < 3; a++) begin
				origin[a] = 0;
				spacing[a] = STEP_ONE;
			end
			radius_sq = 63'd1 << 32;
			run_open = 1'b0;
			open_x = '0;
			open_y = '0;
			open_z = '0;
			open_len = '0;
			mismatches = 0;
		endfunction

		function void set_reg(logic [svr_pkg::CFG_IDX_W-1:0] idx, logic [63:0] value);
			case (idx)
				svr_pkg::REG_ORIGIN_X:  origin[0] = value[31:0];
				svr_pkg::REG_ORIGIN_Y:  origin[1] = value[31:0];
				svr_pkg::REG_ORIGIN_Z:  origin[2] = value[31:0];
				svr_pkg::REG_SPACING_X: spacing[0] = value[30:0];
				svr_pkg::REG_SPACING_Y: spacing[1] = value[30:0];
				svr_pkg::REG_SPACING_Z: spacing[2] = value[30:0];
				svr_pkg::REG_RADIUS_SQ: radius_sq = value[62:0];
				default: ;
			endcase
		endfunction

		// Squared axis offset in Q32.32, offset clamped to signed 32 bits
		function longint unsigned offset_sq(int org, logic [svr_pkg::IDX_W-1:0] idx,
				logic [30:0] step);
			longint s;
			longint unsigned m;
			s = longint'(org) + longint'(idx) * longint'(step);
			if (s > OFS_MAX)
				s = OFS_MAX;
			if (s < OFS_MIN)
				s = OFS_MIN;
			m = (s < 0) ? -s : s;
			return m * m;
		endfunction

		// Closes the open run and returns it as a result
		function svr_pkg::out_item_t close_run(bit is_in);
			svr_pkg::out_item_t r;
			r.inside_res = is_in;
			r.run_done = 1'b1;
			r.run_start_x = open_x;
			r.run_start_y = open_y;
			r.run_start_z = open_z;
			r.run_length = open_len;
			run_open = 1'b0;
			return r;
		endfunction

		function svr_pkg::out_item_t classify_and_track(svr_pkg::in_item_t v);
			longint unsigned d2;
			svr_pkg::out_item_t r;
			bit is_in;
			bit closed;
			d2 = offset_sq(origin[0], v.index_x, spacing[0])
				+ offset_sq(origin[1], v.index_y, spacing[1])
				+ offset_sq(origin[2], v.index_z, spacing[2]);
			is_in = d2 < radius_sq;
			r = '0;
			r.inside_res = is_in;
			closed = 1'b0;
			// row start ends the open run
			if (v.index_x == '0 && run_open) begin
				r = close_run(is_in);
				closed = 1'b1;
			end
			if (is_in) begin
				if (!run_open) begin
					run_open = 1'b1;
					open_x = v.index_x;
					open_y = v.index_y;
					open_z = v.index_z;
					open_len = '0;
				end
				if (open_len < LEN_CAP)
					open_len++;
			end else if (run_open) begin
				r = close_run(is_in);
				closed = 1'b1;
			end
			// end of grid flushes, unless a run was already reported here
			if (v.last_voxel && run_open && !closed)
				r = close_run(is_in);
			return r;
		endfunction

		function void accept_voxel(svr_pkg::in_item_t v);
			due_results.push_back(classify_and_track(v));
		endfunction

		function int pending();
			return due_results.size();
		endfunction

		task report_mismatch(string what);
			mismatches++;
			if (mismatches <= 40)
				$display("mismatch: %s", what);
		endtask

		task match_result(svr_pkg::out_item_t got);
			svr_pkg::out_item_t want;
			if (due_results.size() == 0) begin
				report_mismatch($sformatf("result %h with none owed", got));
				return;
			end
			want = due_results.pop_front();
			if (got.inside_res !== want.inside_res)
				report_mismatch($sformatf("inside_res %b want %b", got.inside_res, want.inside_res));
			if (got.run_done !== want.run_done)
				report_mismatch($sformatf("run_done %b want %b", got.run_done, want.run_done));
			if (got.run_start_x !== want.run_start_x)
				report_mismatch($sformatf("run_start_x %0d want %0d", got.run_start_x,
					want.run_start_x));
			if (got.run_start_y !== want.run_start_y)
				report_mismatch($sformatf("run_start_y %0d want %0d", got.run_start_y,
					want.run_start_y));
			if (got.run_start_z !== want.run_start_z)
				report_mismatch($sformatf("run_start_z %0d want %0d", got.run_start_z,
					want.run_start_z));
			if (got.run_length !== want.run_length)
				report_mismatch($sformatf("run_length %0d want %0d", got.run_length,
					want.run_length));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic psel, penable, pwrite, pready;
	logic [svr_pkg::CFG_ADDR_W-1:0] paddr;
	logic [svr_pkg::CFG_DATA_W-1:0] pwdata, prdata;
	int send_idle_pct = 0;
	int hold_pct = 0;
	int quiet_cycles = 0;
	svr_pkg::in_item_t stim[$];
	voxel_checker sb;

	svr_stream_if #(.T(svr_pkg::in_item_t)) voxel_ch ();
	svr_stream_if #(.T(svr_pkg::out_item_t)) result_ch ();

	sphere_voxelizer_run_length dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.voxel   (voxel_ch),
		.result  (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Receiver stalls at random
	always @(negedge clk) begin
		result_ch.ready <= ($urandom_range(99) >= hold_pct);
	end

	// Accepted items go to the checker
	always @(posedge clk) begin
		if (arst_n) begin
			if (voxel_ch.valid && voxel_ch.ready)
				sb.accept_voxel(voxel_ch.data);
			if (result_ch.valid && result_ch.ready)
				sb.match_result(result_ch.data);
		end
	end

	// Watchdog on cycles with no transfer at all
	always @(posedge clk) begin
		if (arst_n) begin
			if ((voxel_ch.valid && voxel_ch.ready) || (result_ch.valid && result_ch.ready) || psel)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == QUIET_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	function svr_pkg::in_item_t vox(int x, int y, int z, bit last);
		svr_pkg::in_item_t v;
		v.index_x = x[svr_pkg::IDX_W-1:0];
		v.index_y = y[svr_pkg::IDX_W-1:0];
		v.index_z = z[svr_pkg::IDX_W-1:0];
		v.last_voxel = last;
		return v;
	endfunction

	// Raster scan of a small grid, a few voxels dropped
	function void add_scan();
		int nx, ny, nz;
		nx = $urandom_range(1, 16);
		ny = $urandom_range(1, 4);
		nz = $urandom_range(1, 2);
		for (int z = 0; z < nz; z++)
			for (int y = 0; y < ny; y++)
				for (int x = 0; x < nx; x++)
					if ($urandom_range(99) >= 4)
						stim.push_back(vox(x, y, z, x == nx - 1 && y == ny - 1 && z == nz - 1));
	endfunction

	function void add_noise(int n);
		repeat (n)
			stim.push_back(vox($urandom_range(1023), $urandom_range(1023), $urandom_range(1023),
				$urandom_range(7) == 0));
	endfunction

	task set_pace(input int send_pct, input int stall_pct);
		send_idle_pct = send_pct;
		hold_pct = stall_pct;
	endtask

	task write_reg(input logic [svr_pkg::CFG_IDX_W-1:0] idx, input logic [63:0] value);
		logic [svr_pkg::CFG_ADDR_W-1:0] addr;
		addr = '0;
		addr[svr_pkg::CFG_IDX_LSB +: svr_pkg::CFG_IDX_W] = idx;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_reg(idx, value);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task apply_config(input int ox, input int oy, input int oz, input logic [30:0] sx,
			input logic [30:0] sy, input logic [30:0] sz, input logic [63:0] rsq);
		write_reg(svr_pkg::REG_ORIGIN_X, {32'h0, ox});
		write_reg(svr_pkg::REG_ORIGIN_Y, {32'h0, oy});
		write_reg(svr_pkg::REG_ORIGIN_Z, {32'h0, oz});
		write_reg(svr_pkg::REG_SPACING_X, {33'h0, sx});
		write_reg(svr_pkg::REG_SPACING_Y, {33'h0, sy});
		write_reg(svr_pkg::REG_SPACING_Z, {33'h0, sz});
		write_reg(svr_pkg::REG_RADIUS_SQ, rsq);
	endtask

	// Random sphere placed over the scanned grid
	task sphere_config();
		int step[3];
		int reach[3];
		longint unsigned r;
		reach = '{16, 4, 2};
		for (int a = 0; a < 3; a++)
			step[a] = $urandom_range(1 << 12, 1 << 18);
		r = $urandom_range(step[0] / 2, 10 * step[0]);
		apply_config(-$urandom_range(0, reach[0] * step[0]), -$urandom_range(0, reach[1] * step[1]),
			-$urandom_range(0, reach[2] * step[2]), step[0], step[1], step[2], r * r);
	endtask

	task push_voxel(input svr_pkg::in_item_t v);
		int gap;
		gap = 0;
		while (gap < 20 && $urandom_range(99) < send_idle_pct)
			gap++;
		@(negedge clk);
		if (gap > 0) begin
			voxel_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		voxel_ch.valid <= 1'b1;
		voxel_ch.data <= v;
		do @(posedge clk); while (!voxel_ch.ready);
	endtask

	// Sends the queued items, then waits until every result is back
	task feed_and_drain();
		while (stim.size() > 0)
			push_voxel(stim.pop_front());
		@(negedge clk);
		voxel_ch.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task run_phase(input int k);
		case (k % 4)
			0: set_pace(0, 0);
			1: set_pace(55, 0);
			2: set_pace(0, 55);
			default: set_pace(27, 27);
		endcase
		case (k)
			2: apply_config(ORG_MAX, ORG_MAX, ORG_MAX, STEP_MAX, STEP_MAX, STEP_MAX, '1);
			7: apply_config(ORG_MIN, ORG_MIN, 0, 31'd0, 31'd1, STEP_MAX, {1'b0, {63{1'b1}}});
			9: apply_config($urandom, $urandom, $urandom, 31'd1, 31'd1, 31'd1, 64'd0);
			default: sphere_config();
		endcase
		while (stim.size() < PHASE_ITEMS) begin
			if ($urandom_range(99) < 85)
				add_scan();
			else
				add_noise($urandom_range(1, 6));
		end
		feed_and_drain();
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		voxel_ch.valid = 1'b0;
		voxel_ch.data = '0;
		result_ch.ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset values: unit sphere at the grid origin
		set_pace(0, 0);
		stim.push_back(vox(0, 0, 0, 0));
		stim.push_back(vox(1, 0, 0, 0));
		stim.push_back(vox(0, 0, 0, 1));
		feed_and_drain();

		// center at (1,1,0), radius squared 10; unmapped register ignored
		write_reg(REG_UNUSED, {$urandom, $urandom});
		apply_config(-65536, -65536, 0, STEP_ONE, STEP_ONE, STEP_ONE, 64'd10 << 32);
		stim.push_back(vox(0, 1, 0, 0));
		stim.push_back(vox(1, 1, 0, 0));
		stim.push_back(vox(2, 1, 0, 0));
		stim.push_back(vox(3, 1, 0, 0));
		stim.push_back(vox(4, 1, 0, 0));
		stim.push_back(vox(5, 1, 0, 0));
		// exactly on the surface counts as outside
		stim.push_back(vox(4, 2, 0, 0));
		stim.push_back(vox(1, 2, 0, 0));
		stim.push_back(vox(2, 2, 0, 0));
		// row start closes a run and opens the next
		stim.push_back(vox(0, 3, 0, 0));
		// last voxel on a row start: closed run reported, new one stays open
		stim.push_back(vox(0, 2, 0, 1));
		stim.push_back(vox(1, 2, 1, 0));
		stim.push_back(vox(2, 2, 1, 1));
		// single-voxel run flushed by last voxel
		stim.push_back(vox(2, 2, 0, 1));
		stim.push_back(vox(0, 5, 0, 1));
		stim.push_back(vox(3, 3, 3, 0));
		stim.push_back(vox(1023, 1023, 1023, 1));
		stim.push_back(vox(1023, 0, 0, 0));
		stim.push_back(vox(0, 1023, 0, 0));
		stim.push_back(vox(0, 0, 1023, 1));
		stim.push_back(vox(1, 1, 0, 0));
		stim.push_back(vox(512, 1, 0, 1));
		feed_and_drain();

		for (int k = 0; k < 16; k++)
			run_phase(k);

		// one run past the length cap: x never returns to zero
		set_pace(27, 27);
		apply_config(0, 0, 0, 31'd0, 31'd1, 31'd1, {1'b0, {63{1'b1}}});
		repeat (SAT_ITEMS)
			stim.push_back(vox($urandom_range(1, 1023), $urandom_range(1023),
				$urandom_range(1023), 0));
		stim.push_back(vox(0, 7, 7, 0));
		stim.push_back(vox(5, 7, 7, 1));
		feed_and_drain();

		repeat (12) @(posedge clk);
		if (sb.mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
`default_nettype wire
